[rtl/core/cruise_button_input_qualifier_top_macros.svh]
// Assertion macros used by the checker file of the cruise button qualifier.
`ifndef CRUISE_BUTTON_INPUT_QUALIFIER_TOP_MACROS_SVH
`define CRUISE_BUTTON_INPUT_QUALIFIER_TOP_MACROS_SVH

// Checked at every rising edge outside reset.
`define CBIQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CBIQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/cbiq_pkg.sv]
// Shared types and constants of the cruise button input qualifier.
package cbiq_pkg;

    localparam int unsigned NUM_BUTTONS = 4;

    localparam logic [7:0] SPEED_MIN   = 8'd30;
    localparam logic [7:0] SPEED_MAX   = 8'd150;
    localparam logic [7:0] SPEED_STEP  = 8'd5;
    localparam logic [7:0] SPEED_RESET = 8'd90;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd50;

    // Button positions within the fire vector.
    localparam int unsigned BTN_ENGAGE = 0;
    localparam int unsigned BTN_MINUS  = 1;
    localparam int unsigned BTN_PLUS   = 2;
    localparam int unsigned BTN_LANE   = 3;

    // Configuration register indexes.
    localparam logic [2:0] REG_NO_CLUTCH_BRAKE  = 3'd0;
    localparam logic [2:0] REG_DEBUG_MODE       = 3'd1;
    localparam logic [2:0] REG_DEFAULT_SPEED    = 3'd2;
    localparam logic [2:0] REG_CLUTCH_GRACE     = 3'd3;
    localparam logic [2:0] REG_BRAKE_GRACE      = 3'd4;
    localparam logic [2:0] REG_LANE_KEEP_DEF    = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE         = 3'd6;

    // Actuator targets.
    localparam logic [1:0] ACT_THROTTLE = 2'd0;
    localparam logic [1:0] ACT_BRAKE    = 2'd1;
    localparam logic [1:0] ACT_STEERING = 2'd2;

    // Debug commands.
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_DOWN = 2'd1;
    localparam logic [1:0] CMD_UP   = 2'd2;

    typedef struct packed {
        logic        no_clutch_brake;
        logic        debug_mode;
        logic [15:0] clutch_grace;
        logic [15:0] brake_grace;
        logic        lane_keep_default;
        logic [7:0]  debounce;
    } t_cfg;

    typedef struct packed {
        logic       engaged;
        logic       lane_keep;
        logic [7:0] set_speed;
        logic [1:0] debug_target;
        logic [1:0] debug_command;
    } t_ctrl_result;

endpackage

[rtl/core/cruise_button_input_qualifier_top.sv]
// Top level of the cruise button input qualifier.
// Each input transaction is one sample of four active-low buttons, the clutch
// and brake switches and a millisecond tick; each yields exactly one output
// transaction with the engage, lane keep, set speed, pedal and debug status
// after that sample. The block takes one transaction per clock while o_stall
// is low: a sample is captured in an input register, evaluated by a single
// pass of shallow logic that updates the button, pedal and cruise state once
// the output register is free, and the result lands in an output register.
// While the output register holds a stalled result, the input register can
// still hold one more sample; o_stall rises only when both are full and the
// downstream side stalls. Configuration writes are always
// accepted (o_cfg_ready is tied high) and must only be issued while the block
// is idle. Indexes 0 through 6 select no_clutch_brake_mode, debug_mode,
// default_speed, clutch_grace_ms, brake_grace_ms, lane_keep_default and
// debounce_ms; other indexes are ignored. Writing default_speed also
// loads the remembered speed that engaging restores.
module cruise_button_input_qualifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_ms_tick,
    input  logic        i_engage_button,
    input  logic        i_minus_button,
    input  logic        i_plus_button,
    input  logic        i_lane_button,
    input  logic        i_clutch_pin,
    input  logic        i_brake_pin,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_engaged,
    output logic        o_lane_keep,
    output logic [7:0]  o_set_speed,
    output logic        o_clutch_pressed,
    output logic        o_brake_pressed,
    output logic [1:0]  o_debug_target,
    output logic [1:0]  o_debug_command,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    cbiq_pkg::t_cfg         r_cfg;
    cbiq_pkg::t_ctrl_result ctrl_result;

    logic       r_in_valid;
    logic       r_tick;
    logic [3:0] r_buttons;
    logic       r_clutch;
    logic       r_brake;
    logic       r_out_valid;
    logic       out_free;
    logic       process;
    logic       in_take;
    logic       cfg_wr;
    logic [3:0] fire;
    logic       clutch_pressed;
    logic       brake_pressed;

    // Handshake. The output register is free when empty or being drained; the
    // captured sample is evaluated exactly when its result has a place to go.
    assign out_free = !r_out_valid || !i_stall;
    assign process  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.no_clutch_brake   <= 1'b0;
            r_cfg.debug_mode        <= 1'b0;
            r_cfg.clutch_grace      <= 16'd0;
            r_cfg.brake_grace       <= 16'd0;
            r_cfg.lane_keep_default <= 1'b0;
            r_cfg.debounce          <= cbiq_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                cbiq_pkg::REG_NO_CLUTCH_BRAKE: begin
                    r_cfg.no_clutch_brake <= i_cfg_data[0];
                end
                cbiq_pkg::REG_DEBUG_MODE: begin
                    r_cfg.debug_mode <= i_cfg_data[0];
                end
                cbiq_pkg::REG_CLUTCH_GRACE: begin
                    r_cfg.clutch_grace <= i_cfg_data;
                end
                cbiq_pkg::REG_BRAKE_GRACE: begin
                    r_cfg.brake_grace <= i_cfg_data;
                end
                cbiq_pkg::REG_LANE_KEEP_DEF: begin
                    r_cfg.lane_keep_default <= i_cfg_data[0];
                end
                cbiq_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce <= i_cfg_data[7:0];
                end
                default: begin
                    // The default speed lives in the control block as the
                    // remembered speed; unused indexes are ignored.
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tick    <= i_ms_tick;
            r_buttons <= {i_lane_button, i_plus_button, i_minus_button, i_engage_button};
            r_clutch  <= i_clutch_pin;
            r_brake   <= i_brake_pin;
        end
    end

    // Per-button debounce.
    for (genvar g = 0; g < cbiq_pkg::NUM_BUTTONS; g++) begin : g_button
        cbiq_button u_button (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (process),
            .i_level    (r_buttons[g]),
            .i_tick     (r_tick),
            .i_debounce (r_cfg.debounce),
            .o_fire     (fire[g])
        );
    end

    // Pedal switches with release grace time.
    cbiq_release u_clutch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (process),
        .i_pin     (r_clutch),
        .i_tick    (r_tick),
        .i_disable (r_cfg.no_clutch_brake),
        .i_grace   (r_cfg.clutch_grace),
        .o_pressed (clutch_pressed)
    );

    cbiq_release u_brake (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (process),
        .i_pin     (r_brake),
        .i_tick    (r_tick),
        .i_disable (r_cfg.no_clutch_brake),
        .i_grace   (r_cfg.brake_grace),
        .o_pressed (brake_pressed)
    );

    // Cruise state: engage, speed, lane keep and debug actuator.
    cbiq_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (process),
        .i_fire              (fire),
        .i_debug_mode        (r_cfg.debug_mode),
        .i_lane_keep_default (r_cfg.lane_keep_default),
        .i_rem_load          (cfg_wr && (i_cfg_index == cbiq_pkg::REG_DEFAULT_SPEED)),
        .i_rem_value         (i_cfg_data[7:0]),
        .o_result            (ctrl_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            o_engaged        <= ctrl_result.engaged;
            o_lane_keep      <= ctrl_result.lane_keep;
            o_set_speed      <= ctrl_result.set_speed;
            o_debug_target   <= ctrl_result.debug_target;
            o_debug_command  <= ctrl_result.debug_command;
            o_clutch_pressed <= clutch_pressed;
            o_brake_pressed  <= brake_pressed;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/core/cbiq_button.sv]
// Debounce and one-shot press detection for one active-low button.
module cbiq_button (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_level,
    input  logic       i_tick,
    input  logic [7:0] i_debounce,
    output logic       o_fire
);

    logic       r_last;
    logic       r_armed;
    logic [7:0] r_age;
    logic       n_armed;
    logic [7:0] n_age;
    logic       changed;
    logic       armed_pre;

    assign changed = i_level != r_last;

    always_comb begin
        if (changed) begin
            n_age = 8'd0;
        end else if (i_tick && r_age != 8'hFF) begin
            n_age = r_age + 8'd1;
        end else begin
            n_age = r_age;
        end
    end

    assign armed_pre = changed | r_armed;
    assign o_fire    = !i_level && armed_pre && (n_age >= i_debounce);
    assign n_armed   = armed_pre & ~o_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_armed <= 1'b0;
            r_age   <= 8'd0;
        end else if (i_en) begin
            r_last  <= i_level;
            r_armed <= n_armed;
            r_age   <= n_age;
        end
    end

endmodule

[rtl/core/cbiq_release.sv]
// Pedal switch with a hold-off time after release.
module cbiq_release (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_pin,
    input  logic        i_tick,
    input  logic        i_disable,
    input  logic [15:0] i_grace,
    output logic        o_pressed
);

    logic [15:0] r_age;
    logic [15:0] n_age;
    logic        pin_eff;

    // With the pedal mode off the pin is ignored but the age still counts.
    assign pin_eff = i_pin & ~i_disable;

    always_comb begin
        if (pin_eff) begin
            n_age = 16'd0;
        end else if (i_tick && r_age != 16'hFFFF) begin
            n_age = r_age + 16'd1;
        end else begin
            n_age = r_age;
        end
    end

    assign o_pressed = !i_disable && (i_pin || (n_age < i_grace));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= 16'd0;
        end else if (i_en) begin
            r_age <= n_age;
        end
    end

endmodule

[rtl/core/cbiq_ctrl.sv]
// Engage, speed, lane keep and debug actuator state driven by button presses.
module cbiq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [3:0]             i_fire,
    input  logic                   i_debug_mode,
    input  logic                   i_lane_keep_default,
    input  logic                   i_rem_load,
    input  logic [7:0]             i_rem_value,
    output cbiq_pkg::t_ctrl_result o_result
);

    logic       r_engaged;
    logic       r_lane_keep;
    logic [7:0] r_speed;
    logic [7:0] r_remembered;
    logic [1:0] r_act;
    logic       n_engaged;
    logic       n_lane_keep;
    logic [7:0] n_speed;
    logic [7:0] n_remembered;
    logic [1:0] n_act;
    logic [1:0] n_cmd;

    // Buttons are handled in order engage, minus, plus, lane; each sees the
    // effect of the ones before it.
    always_comb begin
        n_engaged    = r_engaged;
        n_lane_keep  = r_lane_keep;
        n_speed      = r_speed;
        n_remembered = r_remembered;
        n_act        = r_act;
        n_cmd        = cbiq_pkg::CMD_NONE;

        if (i_fire[cbiq_pkg::BTN_ENGAGE]) begin
            if (r_engaged) begin
                n_engaged = 1'b0;
            end else if (!i_debug_mode) begin
                n_engaged   = 1'b1;
                n_speed     = r_remembered;
                n_lane_keep = i_lane_keep_default;
            end
            if (i_debug_mode) begin
                n_act = (r_act >= cbiq_pkg::ACT_STEERING) ? cbiq_pkg::ACT_THROTTLE
                                                           : r_act + 2'd1;
            end
        end

        if (i_fire[cbiq_pkg::BTN_MINUS]) begin
            if (i_debug_mode) begin
                n_cmd = cbiq_pkg::CMD_DOWN;
            end else if (n_speed > cbiq_pkg::SPEED_MIN) begin
                n_speed      = n_speed - cbiq_pkg::SPEED_STEP;
                n_remembered = n_speed;
            end
        end

        if (i_fire[cbiq_pkg::BTN_PLUS]) begin
            if (i_debug_mode) begin
                n_cmd = cbiq_pkg::CMD_UP;
            end else if (n_speed < cbiq_pkg::SPEED_MAX) begin
                n_speed      = n_speed + cbiq_pkg::SPEED_STEP;
                n_remembered = n_speed;
            end
        end

        if (i_fire[cbiq_pkg::BTN_LANE] && !i_debug_mode && n_engaged) begin
            n_lane_keep = ~n_lane_keep;
        end
    end

    assign o_result.engaged       = n_engaged;
    assign o_result.lane_keep     = n_lane_keep;
    assign o_result.set_speed     = n_speed;
    assign o_result.debug_target  = n_act;
    assign o_result.debug_command = n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engaged    <= 1'b0;
            r_lane_keep  <= 1'b0;
            r_speed      <= cbiq_pkg::SPEED_RESET;
            r_remembered <= cbiq_pkg::SPEED_RESET;
            r_act        <= cbiq_pkg::ACT_THROTTLE;
        end else begin
            if (i_en) begin
                r_engaged   <= n_engaged;
                r_lane_keep <= n_lane_keep;
                r_speed     <= n_speed;
                r_act       <= n_act;
            end
            // A write of the default speed also reloads the remembered speed.
            if (i_rem_load) begin
                r_remembered <= i_rem_value;
            end else if (i_en) begin
                r_remembered <= n_remembered;
            end
        end
    end

endmodule

[rtl/core/cbiq_checker.sv]
// Port-level assertions for the cruise button input qualifier, bound to the top level.
`include "cruise_button_input_qualifier_top_macros.svh"

module cbiq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_set_speed,
    input logic [1:0]  o_debug_target
);

    // A stalled result stays offered with the same speed.
    `CBIQ_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_set_speed), "stalled result dropped or changed")

    // Every accepted transaction has a result on offer once it has passed the input and output registers.
    `CBIQ_ASSERT(a_latency, i_valid && !o_stall |-> ##2 o_valid, "no result two cycles after acceptance")

    // The actuator cycle never reaches the unused code.
    `CBIQ_ASSERT(a_target_range, o_valid |-> o_debug_target != 2'd3, "debug target out of range")

    // Reset leaves no result on offer.
    `CBIQ_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind cruise_button_input_qualifier_top cbiq_checker u_cbiq_checker (.*);

[verif/cbiq_status_checker.sv]
// Checker that predicts the qualifier status for each accepted sample and compares results.
module cbiq_status_checker
    import cbiq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample channel, watched only.
    input  logic        i_sample_valid,
    input  logic        i_sample_stall,
    input  logic        i_ms_tick,
    input  logic        i_engage_button,
    input  logic        i_minus_button,
    input  logic        i_plus_button,
    input  logic        i_lane_button,
    input  logic        i_clutch_pin,
    input  logic        i_brake_pin,
    // Result channel, watched only.
    input  logic        i_result_valid,
    input  logic        i_result_stall,
    input  logic        i_engaged,
    input  logic        i_lane_keep,
    input  logic [7:0]  i_set_speed,
    input  logic        i_clutch_pressed,
    input  logic        i_brake_pressed,
    input  logic [1:0]  i_debug_target,
    input  logic [1:0]  i_debug_command,
    // Configuration write channel, watched only.
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       engaged;
        logic       lane_keep;
        logic [7:0] set_speed;
        logic       clutch_pressed;
        logic       brake_pressed;
        logic [1:0] debug_target;
        logic [1:0] debug_command;
    } t_status;

    // Register copies.
    logic        cfg_no_pedals;
    logic        cfg_debug;
    logic [15:0] cfg_clutch_grace;
    logic [15:0] cfg_brake_grace;
    logic        cfg_lane_default;
    logic [7:0]  cfg_debounce;

    // Predicted block state.
    logic [NUM_BUTTONS-1:0] btn_last;
    logic [NUM_BUTTONS-1:0] btn_armed;
    logic [7:0]             btn_age [NUM_BUTTONS];
    logic [15:0]            clutch_age;
    logic [15:0]            brake_age;
    logic                   engaged_st;
    logic                   lane_st;
    logic [7:0]             speed_st;
    logic [7:0]             remembered_speed;
    logic [1:0]             act_sel;

    t_status status_q [$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [15:0] release_age_next(logic [15:0] age, logic pin, logic tick);
        if (pin) begin
            return 16'd0;
        end
        if (tick && age != 16'hFFFF) begin
            return age + 16'd1;
        end
        return age;
    endfunction

    // Any level change re-arms the button; a low, armed, settled button fires once.
    function automatic logic debounce_button(int b, logic level, logic tick);
        logic fired;
        fired = 1'b0;
        if (level != btn_last[b]) begin
            btn_age[b]   = 8'd0;
            btn_armed[b] = 1'b1;
        end else if (tick && btn_age[b] != 8'hFF) begin
            btn_age[b] = btn_age[b] + 8'd1;
        end
        btn_last[b] = level;
        if (!level && btn_armed[b] && btn_age[b] >= cfg_debounce) begin
            btn_armed[b] = 1'b0;
            fired        = 1'b1;
        end
        return fired;
    endfunction

    function automatic t_status qualify_sample(logic tick, logic [3:0] level, logic clutch,
                                               logic brake);
        t_status                st;
        logic [NUM_BUTTONS-1:0] fire;
        st = '0;
        st.debug_command = CMD_NONE;
        if (cfg_no_pedals) begin
            clutch_age = release_age_next(clutch_age, 1'b0, tick);
            brake_age  = release_age_next(brake_age, 1'b0, tick);
        end else begin
            clutch_age = release_age_next(clutch_age, clutch, tick);
            brake_age  = release_age_next(brake_age, brake, tick);
            st.clutch_pressed = clutch || (clutch_age < cfg_clutch_grace);
            st.brake_pressed  = brake || (brake_age < cfg_brake_grace);
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            fire[b] = debounce_button(b, level[b], tick);
        end
        if (fire[BTN_ENGAGE]) begin
            if (engaged_st) begin
                engaged_st = 1'b0;
            end else if (!cfg_debug) begin
                engaged_st = 1'b1;
                speed_st   = remembered_speed;
                lane_st    = cfg_lane_default;
            end
            if (cfg_debug) begin
                act_sel = (act_sel >= ACT_STEERING) ? ACT_THROTTLE : act_sel + 2'd1;
            end
        end
        if (fire[BTN_MINUS]) begin
            if (cfg_debug) begin
                st.debug_command = CMD_DOWN;
            end else if (speed_st > SPEED_MIN) begin
                speed_st         = speed_st - SPEED_STEP;
                remembered_speed = speed_st;
            end
        end
        if (fire[BTN_PLUS]) begin
            if (cfg_debug) begin
                st.debug_command = CMD_UP;
            end else if (speed_st < SPEED_MAX) begin
                speed_st         = speed_st + SPEED_STEP;
                remembered_speed = speed_st;
            end
        end
        if (fire[BTN_LANE] && !cfg_debug && engaged_st) begin
            lane_st = ~lane_st;
        end
        st.engaged      = engaged_st;
        st.lane_keep    = lane_st;
        st.set_speed    = speed_st;
        st.debug_target = act_sel;
        return st;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // All channel signals are read at the rising edge, before any of them is updated.
    always @(posedge i_clk) begin : watch
        t_status want;
        if (!i_rst_n) begin
            cfg_no_pedals     = 1'b0;
            cfg_debug         = 1'b0;
            cfg_clutch_grace  = 16'd0;
            cfg_brake_grace   = 16'd0;
            cfg_lane_default  = 1'b0;
            cfg_debounce      = DEBOUNCE_RESET;
            btn_last          = '0;
            btn_armed         = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                btn_age[b] = 8'd0;
            end
            clutch_age       = 16'd0;
            brake_age        = 16'd0;
            engaged_st       = 1'b0;
            lane_st          = 1'b0;
            speed_st         = SPEED_RESET;
            remembered_speed = SPEED_RESET;
            act_sel          = ACT_THROTTLE;
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_NO_CLUTCH_BRAKE: cfg_no_pedals    = i_cfg_data[0];
                    REG_DEBUG_MODE:      cfg_debug        = i_cfg_data[0];
                    REG_DEFAULT_SPEED: begin
                        remembered_speed  = i_cfg_data[7:0];
                    end
                    REG_CLUTCH_GRACE:    cfg_clutch_grace = i_cfg_data;
                    REG_BRAKE_GRACE:     cfg_brake_grace  = i_cfg_data;
                    REG_LANE_KEEP_DEF:   cfg_lane_default = i_cfg_data[0];
                    REG_DEBOUNCE:        cfg_debounce     = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_result_valid && !i_result_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with no sample outstanding, actual speed %0d",
                             $time, i_set_speed);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("engaged", want.engaged, i_engaged);
                    check_field("lane_keep", want.lane_keep, i_lane_keep);
                    check_field("set_speed", want.set_speed, i_set_speed);
                    check_field("clutch_pressed", want.clutch_pressed, i_clutch_pressed);
                    check_field("brake_pressed", want.brake_pressed, i_brake_pressed);
                    check_field("debug_target", want.debug_target, i_debug_target);
                    check_field("debug_command", want.debug_command, i_debug_command);
                end
            end
            if (i_sample_valid && !i_sample_stall) begin
                status_q.push_back(qualify_sample(i_ms_tick,
                    {i_lane_button, i_plus_button, i_minus_button, i_engage_button},
                    i_clutch_pin, i_brake_pin));
            end
        end
        o_pending_count = status_q.size();
    end

endmodule

[verif/tb_cruise_button_input_qualifier_top.sv]
// Testbench top for the cruise button input qualifier: stimulus, stalls and verdict.
module tb_cruise_button_input_qualifier_top;
    import cbiq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Every input of the block starts from a known value.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        i_ms_tick       = 1'b0;
    logic        i_engage_button = 1'b1;
    logic        i_minus_button  = 1'b1;
    logic        i_plus_button   = 1'b1;
    logic        i_lane_button   = 1'b1;
    logic        i_clutch_pin    = 1'b0;
    logic        i_brake_pin     = 1'b0;
    logic        i_stall         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [2:0]  i_cfg_index     = '0;
    logic [15:0] i_cfg_data      = '0;

    logic        o_stall;
    logic        o_valid;
    logic        o_engaged;
    logic        o_lane_keep;
    logic [7:0]  o_set_speed;
    logic        o_clutch_pressed;
    logic        o_brake_pressed;
    logic [1:0]  o_debug_target;
    logic [1:0]  o_debug_command;
    logic        o_cfg_ready;

    int fail_count;
    int pending_count;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int idle_pct  = 20;
    int stall_pct = 20;

    // Current pin levels of the random walk. Bit order follows the button
    // positions of the package: engage, minus, plus, lane.
    logic [3:0] levels    = 4'b1111;
    logic       clutch_on = 1'b0;
    logic       brake_on  = 1'b0;

    cruise_button_input_qualifier_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ms_tick        (i_ms_tick),
        .i_engage_button  (i_engage_button),
        .i_minus_button   (i_minus_button),
        .i_plus_button    (i_plus_button),
        .i_lane_button    (i_lane_button),
        .i_clutch_pin     (i_clutch_pin),
        .i_brake_pin      (i_brake_pin),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_engaged        (o_engaged),
        .o_lane_keep      (o_lane_keep),
        .o_set_speed      (o_set_speed),
        .o_clutch_pressed (o_clutch_pressed),
        .o_brake_pressed  (o_brake_pressed),
        .o_debug_target   (o_debug_target),
        .o_debug_command  (o_debug_command),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // The checker watches all three channels, predicts each result and
    // reports how many fields went wrong and how many results are still owed.
    cbiq_status_checker status_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_valid),
        .i_sample_stall   (o_stall),
        .i_ms_tick        (i_ms_tick),
        .i_engage_button  (i_engage_button),
        .i_minus_button   (i_minus_button),
        .i_plus_button    (i_plus_button),
        .i_lane_button    (i_lane_button),
        .i_clutch_pin     (i_clutch_pin),
        .i_brake_pin      (i_brake_pin),
        .i_result_valid   (o_valid),
        .i_result_stall   (i_stall),
        .i_engaged        (o_engaged),
        .i_lane_keep      (o_lane_keep),
        .i_set_speed      (o_set_speed),
        .i_clutch_pressed (o_clutch_pressed),
        .i_brake_pressed  (o_brake_pressed),
        .i_debug_target   (o_debug_target),
        .i_debug_command  (o_debug_command),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls at random; a zero percentage turns stalls off entirely.
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Offers one sample and returns at the edge that accepts it, with valid
    // still high so that the next sample can follow without a bubble.
    task automatic send_sample(logic tick, logic [3:0] lv, logic clutch, logic brake);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_ms_tick       <= tick;
        i_engage_button <= lv[BTN_ENGAGE];
        i_minus_button  <= lv[BTN_MINUS];
        i_plus_button   <= lv[BTN_PLUS];
        i_lane_button   <= lv[BTN_LANE];
        i_clutch_pin    <= clutch;
        i_brake_pin     <= brake;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Writes one register. Bits above the register width carry random junk,
    // which the block has to drop. Valid stays high for a following write.
    task automatic cfg_write(logic [2:0] idx, logic [15:0] value, int width);
        logic [31:0] junk;
        junk = $urandom << width;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= junk[15:0] | value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stops sending and waits until every result has come back. The pending
    // count is updated by the checker at the rising edge, so it is read at
    // the falling edge; the task then lets the two-stage pipeline settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random walk of the pins. Buttons in the mask change level with the
    // given chance, so presses and releases are usually held for several
    // samples; now and then any button, masked or not, also flips its level.
    task automatic run_random(int count, int toggle_pct, logic [3:0] mask, int tick_pct);
        for (int k = 0; k < count; k++) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (mask[b] && $urandom_range(99) < toggle_pct) begin
                    levels[b] = ~levels[b];
                end
            end
            if ($urandom_range(99) < 8) begin
                levels[$urandom_range(NUM_BUTTONS - 1)] ^= 1'b1;
            end
            if ($urandom_range(99) < 10) begin
                clutch_on = ~clutch_on;
            end
            if ($urandom_range(99) < 10) begin
                brake_on = ~brake_on;
            end
            send_sample($urandom_range(99) < tick_pct, levels, clutch_on, brake_on);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A zero debounce fires on the changing sample itself.
        // Nonzero grace times written right after reset make the pedals read
        // pressed until enough ticks have passed, pins low or not.
        // Button vectors below read {lane, plus, minus, engage}, 0 = pressed.
        cfg_write(REG_DEBOUNCE, 16'd0, 8);
        cfg_write(REG_CLUTCH_GRACE, 16'd2, 16);
        cfg_write(REG_BRAKE_GRACE, 16'd1, 16);
        i_cfg_valid <= 1'b0;
        send_sample(1'b0, 4'b1111, 1'b0, 1'b0);  // arms every button, no press
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b1110, 1'b0, 1'b0);  // engage, speed restored
        send_sample(1'b1, 4'b1111, 1'b1, 1'b1);
        send_sample(1'b0, 4'b1011, 1'b1, 1'b0);  // plus
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b0, 4'b1101, 1'b0, 1'b1);  // minus
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b0111, 1'b0, 1'b0);  // lane keep toggles on
        send_sample(1'b0, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b1001, 1'b0, 1'b0);  // minus then plus in one sample
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b1110, 1'b0, 1'b0);  // disengage
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b0111, 1'b0, 1'b0);  // lane is ignored while disengaged
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b0110, 1'b1, 1'b1);  // engage, then lane sees it engaged
        send_sample(1'b0, 4'b0110, 1'b1, 1'b1);  // held low: no second firing
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        send_sample(1'b1, 4'b0000, 1'b0, 1'b0);  // all four buttons at once
        send_sample(1'b1, 4'b1111, 1'b1, 1'b0);

        // Short debounce with a long brake grace and lane keep on by default.
        // The sender also pauses midway until every result has drained.
        wait_idle();
        cfg_write(REG_DEBOUNCE, 16'd1, 8);
        cfg_write(REG_CLUTCH_GRACE, 16'd5, 16);
        cfg_write(REG_BRAKE_GRACE, 16'd300, 16);
        cfg_write(REG_LANE_KEEP_DEF, 16'd1, 1);
        cfg_write(REG_DEFAULT_SPEED, 16'd100, 8);
        i_cfg_valid <= 1'b0;
        run_random(120, 15, 4'b1111, 60);
        wait_idle();
        run_random(120, 15, 4'b1111, 60);

        // Debug mode: engaging is blocked, engage cycles the actuator and
        // minus and plus become down and up commands. An engage press still
        // drops an engage left by the previous phase. The default speed written
        // here lies above the upper speed bound.
        wait_idle();
        cfg_write(REG_DEBUG_MODE, 16'd1, 1);
        cfg_write(REG_DEBOUNCE, 16'd0, 8);
        cfg_write(REG_DEFAULT_SPEED, 16'd255, 8);
        i_cfg_valid <= 1'b0;
        run_random(200, 20, 4'b1111, 50);

        // Pedals forced off while their release ages keep counting, with the
        // largest grace times and a zero default speed.
        wait_idle();
        cfg_write(REG_DEBUG_MODE, 16'd0, 1);
        cfg_write(REG_NO_CLUTCH_BRAKE, 16'd1, 1);
        cfg_write(REG_DEBOUNCE, 16'd2, 8);
        cfg_write(REG_DEFAULT_SPEED, 16'd0, 8);
        cfg_write(REG_CLUTCH_GRACE, 16'hFFFF, 16);
        cfg_write(REG_BRAKE_GRACE, 16'hFFFF, 16);
        i_cfg_valid <= 1'b0;
        run_random(100, 20, 4'b1111, 70);

        // Pedals back on; engaging now restores a speed above the upper bound.
        wait_idle();
        cfg_write(REG_NO_CLUTCH_BRAKE, 16'd0, 1);
        cfg_write(REG_DEFAULT_SPEED, 16'd255, 8);
        i_cfg_valid <= 1'b0;
        run_random(100, 20, 4'b1111, 70);

        // Longest debounce: engage held low with a tick on every sample until
        // its age saturates. Neither side idles during this stretch.
        wait_idle();
        cfg_write(REG_DEBOUNCE, 16'd255, 8);
        cfg_write(REG_LANE_KEEP_DEF, 16'd0, 1);
        i_cfg_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        send_sample(1'b1, 4'b1111, 1'b0, 1'b0);
        for (int k = 0; k < 257; k++) begin
            send_sample(1'b1, 4'b1110, 1'b0, 1'b0);
        end
        levels    = 4'b1110;
        clutch_on = 1'b0;
        brake_on  = 1'b0;
        idle_pct  = 20;
        stall_pct = 20;

        // Speed limits: the walk first toggles mainly plus, then mainly minus, to
        // push the speed against its ceiling and its floor. The write to the unused
        // index must change nothing.
        wait_idle();
        cfg_write(REG_DEBOUNCE, 16'd0, 8);
        cfg_write(REG_DEFAULT_SPEED, 16'd150, 8);
        cfg_write(REG_CLUTCH_GRACE, 16'd0, 16);
        cfg_write(REG_BRAKE_GRACE, 16'd0, 16);
        cfg_write(REG_UNUSED, 16'($urandom), 16);
        i_cfg_valid <= 1'b0;
        run_random(100, 40, 4'b0100, 50);
        run_random(150, 40, 4'b0010, 50);

        wait_idle();
        if (fail_count == 0) begin
            $display("cruise_button_input_qualifier_top: match");
        end else begin
            $display("cruise_button_input_qualifier_top: mismatch");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("cruise_button_input_qualifier_top: mismatch");
        $finish;
    end

endmodule
